>>> design/sts_pkg.sv
`default_nettype none
package sts_pkg;
    localparam int CW = 16;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    typedef enum logic [12:0] {
        M_IDLE    = 13'b0000000000001,
        M_NPEND   = 13'b0000000000010,
        M_IDENT   = 13'b0000000000100,
        M_AT      = 13'b0000000001000,
        M_VAR     = 13'b0000000010000,
        M_INT     = 13'b0000000100000,
        M_INTDOT  = 13'b0000001000000,
        M_DEC     = 13'b0000010000000,
        M_STR     = 13'b0000100000000,
        M_USTR    = 13'b0001000000000,
        M_BRACK   = 13'b0010000000000,
        M_OPPEND  = 13'b0100000000000,
        M_MINUSGT = 13'b1000000000000
    } mode_t;

    localparam logic [4:0] K_IDENT = 5'd0, K_INT = 5'd1, K_DEC = 5'd2, K_STR = 5'd3,
        K_USTR = 5'd4, K_VAR = 5'd5, K_LPAR = 5'd6, K_RPAR = 5'd7, K_COMMA = 5'd8,
        K_SEMI = 5'd9, K_DOT = 5'd10, K_PLUS = 5'd11, K_STAR = 5'd12, K_SLASH = 5'd13,
        K_PCT = 5'd14, K_EQ = 5'd15, K_MINUS = 5'd16, K_ARROW2 = 5'd17, K_ARROW = 5'd18,
        K_LE = 5'd19, K_NE = 5'd20, K_LT = 5'd21, K_GE = 5'd22, K_GT = 5'd23,
        K_INVALID = 5'd24, K_EOF = 5'd25;

    localparam logic [2:0] E_NONE = 3'd0, E_UNTERM_BRACK = 3'd1, E_EMPTY_BRACK = 3'd2,
        E_BAD_VAR = 3'd3, E_UNTERM_STR = 3'd4, E_LONE_BANG = 3'd5, E_UNEXPECTED = 3'd6;

    typedef struct packed {
        logic [4:0]    kind;
        logic [CW-1:0] off;
        logic [CW-1:0] len;
        logic [CW-1:0] line;
        logic [CW-1:0] col;
        logic [2:0]    err;
        logic          last;
    } rec_t;

    typedef struct packed {
        rec_t [3:0] recs;
        logic [2:0] count;
    } batch_t;

    localparam int QD = 4;
    localparam int QAW = 2;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] x);
        return (x == CMAX) ? x : x + 1'b1;
    endfunction
endpackage
`default_nettype wire

>>> design/sql_token_scanner.sv
// SQL token scanner.
// Input channel: in_valid / in_stall with req_type and ch. One source byte per
// transaction, or an end-of-source marker (req_type = 1) that flushes any open
// token, emits an end-of-file record unless an error halted the scan, and
// returns the scanner to its start state. Output channel: out_valid /
// out_stall with one token record per transaction; last_of_run marks the last
// record caused by one input transaction. Each input byte is classified by
// the front state machine; its records, if any (up to four), are written as
// one entry into a four-entry queue. The back end drains one record per cycle
// unless stalled, so a record appears in the cycle after its byte at the
// earliest. Bytes are taken every cycle while the queue has room; throughput
// is one byte per cycle, or one record per cycle when the output is the
// bottleneck. A stalled receiver holds the current record; the queue then
// fills and in_stall rises. Reset clears the scanner and empties the queue.
`default_nettype none
module sql_token_scanner
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         req_type,
    input  wire  [7:0]  ch,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] text_offset,
    output logic [15:0] text_length,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic [2:0]  error_code,
    output logic        last_of_run
);
    import sts_pkg::*;

    batch_t batch;
    rec_t   rec;
    logic   full, empty;

    assign in_stall = full;

    sts_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_type(req_type),
        .in_ch(ch), .take(!full), .batch(batch)
    );

    sts_back u_back
    (
        .clk(clk), .rst_n(rst_n), .batch(batch), .full(full), .empty(empty),
        .out_valid(out_valid), .out_stall(out_stall), .out_rec(rec)
    );

    assign token_kind = rec.kind;
    assign text_offset = rec.off;
    assign text_length = rec.len;
    assign token_line = rec.line;
    assign token_column = rec.col;
    assign error_code = rec.err;
    assign last_of_run = rec.last;

    a_err_only_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind != K_INVALID |-> error_code == E_NONE)
        else $error("error code on a valid token");
    a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && token_kind == K_EOF |-> last_of_run)
        else $error("end-of-file record not last");
    a_stall_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !empty || !in_stall)
        else $error("stall with empty queue");
endmodule
`default_nettype wire

>>> design/sts_front.sv
`default_nettype none
module sts_front
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    input  wire                 in_type,
    input  wire [7:0]           in_ch,
    input  wire                 take,
    output sts_pkg::batch_t     batch
);
    import sts_pkg::*;

    mode_t         mode_reg, mode_next;
    logic [7:0]    held_reg, held_next;
    logic [CW-1:0] tb_reg, tb_next, xb_reg, xb_next;
    logic [CW-1:0] sl_reg, sl_next, sc_reg, sc_next;
    logic [CW-1:0] lc_reg, lc_next, lb_reg, lb_next, bp_reg, bp_next;
    logic          esc_reg, esc_next, halt_reg, halt_next;

    rec_t [3:0] r;
    logic [2:0] n;

    function automatic logic is_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    always_comb
    begin
        logic [7:0]    c;
        logic [CW-1:0] p, d;
        logic          redo;
        logic [CW-1:0] colp, colx;
        c = in_ch;
        p = bp_reg;
        mode_next = mode_reg; held_next = held_reg; tb_next = tb_reg; xb_next = xb_reg;
        sl_next = sl_reg; sc_next = sc_reg; lc_next = lc_reg; lb_next = lb_reg;
        bp_next = bp_reg; esc_next = esc_reg; halt_next = halt_reg;
        r = '0;
        n = 3'd0;
        redo = 1'b0;
        d = (p >= lb_reg) ? p - lb_reg : '0;
        colp = sat_inc(d);
        d = (xb_reg >= lb_reg) ? xb_reg - lb_reg : '0;
        colx = sat_inc(d);
        if (in_valid && take)
        begin
            if (in_type)
            begin
                if (!halt_reg)
                begin
                    unique case (mode_reg)
                        M_NPEND, M_IDENT:
                        begin r[0] = '{K_IDENT, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0}; n = 3'd1; end
                        M_AT:
                        begin
                            r[0] = '{K_INVALID, tb_reg, 16'd1, sl_reg, sc_reg, E_BAD_VAR, 1'b0};
                            r[1] = '{K_EOF, tb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b1}; n = 3'd2;
                        end
                        M_VAR:
                        begin r[0] = '{K_VAR, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0}; n = 3'd1; end
                        M_INT:
                        begin r[0] = '{K_INT, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0}; n = 3'd1; end
                        M_INTDOT:
                        begin
                            r[0] = '{K_INT, tb_reg, xb_reg - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                            r[1] = '{K_DOT, xb_reg, 16'd1, lc_reg, colx, E_NONE, 1'b0}; n = 3'd2;
                        end
                        M_DEC:
                        begin r[0] = '{K_DEC, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0}; n = 3'd1; end
                        M_STR, M_USTR:
                        begin
                            r[0] = '{K_INVALID, tb_reg, p - tb_reg, sl_reg, sc_reg, E_UNTERM_STR, 1'b0};
                            r[1] = '{K_EOF, tb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b1}; n = 3'd2;
                        end
                        M_BRACK:
                        begin
                            r[0] = '{K_INVALID, xb_reg, p - xb_reg, sl_reg, sc_reg, E_UNTERM_BRACK, 1'b0};
                            r[1] = '{K_EOF, xb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b1}; n = 3'd2;
                        end
                        M_OPPEND:
                        begin
                            n = 3'd1;
                            priority if (held_reg == 8'h2d)
                                r[0] = '{K_MINUS, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0};
                            else if (held_reg == 8'h3c)
                                r[0] = '{K_LT, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0};
                            else if (held_reg == 8'h3e)
                                r[0] = '{K_GT, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0};
                            else
                            begin
                                r[0] = '{K_INVALID, tb_reg, 16'd1, sl_reg, sc_reg, E_LONE_BANG, 1'b0};
                                r[1] = '{K_EOF, tb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b1}; n = 3'd2;
                            end
                        end
                        M_MINUSGT:
                        begin r[0] = '{K_ARROW, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0}; n = 3'd1; end
                        default: ;
                    endcase
                    if (!(n == 3'd2 && r[1].last))
                    begin
                        r[n[1:0]] = '{K_EOF, p, 16'd0, lc_reg, colp, E_NONE, 1'b1};
                        n = n + 3'd1;
                    end
                end
                mode_next = M_IDLE; held_next = '0; tb_next = '0; xb_next = '0;
                sl_next = 16'd1; sc_next = 16'd1; lc_next = 16'd1; lb_next = '0;
                bp_next = '0; esc_next = 1'b0; halt_next = 1'b0;
            end
            else if (!halt_reg)
            begin
                bp_next = sat_inc(p);
                unique case (mode_reg)
                    M_NPEND:
                        if (c == 8'h27)
                        begin
                            mode_next = M_USTR; tb_next = p; xb_next = sat_inc(p); esc_next = 1'b0;
                        end
                        else if (is_start(c) || is_digit(c)) mode_next = M_IDENT;
                        else
                        begin
                            r[0] = '{K_IDENT, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd1; redo = 1'b1;
                        end
                    M_IDENT, M_VAR:
                        if (!(is_start(c) || is_digit(c)))
                        begin
                            r[0] = '{(mode_reg == M_IDENT) ? K_IDENT : K_VAR, tb_reg, p - tb_reg,
                                     sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd1; redo = 1'b1;
                        end
                    M_AT:
                        if (is_start(c)) mode_next = M_VAR;
                        else
                        begin
                            r[0] = '{K_INVALID, tb_reg, 16'd1, sl_reg, sc_reg, E_BAD_VAR, 1'b0};
                            r[1] = '{K_EOF, tb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd2; halt_next = 1'b1; mode_next = M_IDLE;
                        end
                    M_INT:
                        if (c == 8'h2e) begin xb_next = p; mode_next = M_INTDOT; end
                        else if (!is_digit(c))
                        begin
                            r[0] = '{K_INT, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd1; redo = 1'b1;
                        end
                    M_INTDOT:
                        if (is_digit(c)) mode_next = M_DEC;
                        else
                        begin
                            r[0] = '{K_INT, tb_reg, xb_reg - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                            r[1] = '{K_DOT, xb_reg, 16'd1, lc_reg, colx, E_NONE, 1'b0};
                            n = 3'd2; redo = 1'b1;
                        end
                    M_DEC:
                        if (!is_digit(c))
                        begin
                            r[0] = '{K_DEC, tb_reg, p - tb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd1; redo = 1'b1;
                        end
                    M_STR, M_USTR:
                        if (esc_reg)
                        begin
                            esc_next = 1'b0;
                            if (c == 8'h0a) begin lc_next = sat_inc(lc_reg); lb_next = sat_inc(p); end
                        end
                        else if (c == 8'h27)
                        begin
                            r[0] = '{(mode_reg == M_STR) ? K_STR : K_USTR, xb_reg, p - xb_reg,
                                     sl_reg, sc_reg, E_NONE, 1'b0};
                            n = 3'd1; mode_next = M_IDLE;
                        end
                        else if (c == 8'h5c) esc_next = 1'b1;
                        else if (c == 8'h0a)
                        begin lc_next = sat_inc(lc_reg); lb_next = sat_inc(p); end
                    M_BRACK:
                        if (c == 8'h5d)
                        begin
                            if (p == xb_reg)
                            begin
                                r[0] = '{K_INVALID, xb_reg, 16'd0, sl_reg, sc_reg, E_EMPTY_BRACK, 1'b0};
                                r[1] = '{K_EOF, xb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b0};
                                n = 3'd2; halt_next = 1'b1;
                            end
                            else
                            begin
                                r[0] = '{K_IDENT, xb_reg, p - xb_reg, sl_reg, sc_reg, E_NONE, 1'b0};
                                n = 3'd1;
                            end
                            mode_next = M_IDLE;
                        end
                        else if (c == 8'h0a)
                        begin lc_next = sat_inc(lc_reg); lb_next = sat_inc(p); end
                    M_OPPEND:
                    begin
                        mode_next = M_IDLE; n = 3'd1;
                        priority if (held_reg == 8'h2d)
                        begin
                            if (c == 8'h3e) begin mode_next = M_MINUSGT; n = 3'd0; end
                            else begin r[0] = '{K_MINUS, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0}; redo = 1'b1; end
                        end
                        else if (held_reg == 8'h3c)
                        begin
                            if (c == 8'h3d) r[0] = '{K_LE, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0};
                            else if (c == 8'h3e) r[0] = '{K_NE, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0};
                            else begin r[0] = '{K_LT, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0}; redo = 1'b1; end
                        end
                        else if (held_reg == 8'h3e)
                        begin
                            if (c == 8'h3d) r[0] = '{K_GE, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0};
                            else begin r[0] = '{K_GT, tb_reg, 16'd1, sl_reg, sc_reg, E_NONE, 1'b0}; redo = 1'b1; end
                        end
                        else
                        begin
                            if (c == 8'h3d) r[0] = '{K_NE, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0};
                            else
                            begin
                                r[0] = '{K_INVALID, tb_reg, 16'd1, sl_reg, sc_reg, E_LONE_BANG, 1'b0};
                                r[1] = '{K_EOF, tb_reg, 16'd0, sl_reg, sc_reg, E_NONE, 1'b0};
                                n = 3'd2; halt_next = 1'b1;
                            end
                        end
                    end
                    M_MINUSGT:
                    begin
                        mode_next = M_IDLE; n = 3'd1;
                        if (c == 8'h3e) r[0] = '{K_ARROW2, tb_reg, 16'd3, sl_reg, sc_reg, E_NONE, 1'b0};
                        else begin r[0] = '{K_ARROW, tb_reg, 16'd2, sl_reg, sc_reg, E_NONE, 1'b0}; redo = 1'b1; end
                    end
                    default: redo = 1'b1;
                endcase
                if (redo)
                begin
                    mode_next = M_IDLE;
                    if (c == 8'h0a)
                    begin lc_next = sat_inc(lc_reg); lb_next = sat_inc(p); end
                    else if (c != 8'h20 && c != 8'h09 && c != 8'h0d)
                    begin
                        sl_next = lc_reg; sc_next = colp; tb_next = p;
                        priority if (c == 8'h4e || c == 8'h6e)
                        begin mode_next = M_NPEND; held_next = c; end
                        else if (is_start(c)) mode_next = M_IDENT;
                        else if (is_digit(c)) mode_next = M_INT;
                        else if (c == 8'h27)
                        begin mode_next = M_STR; xb_next = sat_inc(p); esc_next = 1'b0; end
                        else if (c == 8'h5b) begin mode_next = M_BRACK; xb_next = sat_inc(p); end
                        else if (c == 8'h40) mode_next = M_AT;
                        else if (c == 8'h2d || c == 8'h3c || c == 8'h3e || c == 8'h21)
                        begin mode_next = M_OPPEND; held_next = c; end
                        else
                        begin
                            logic [4:0] k;
                            k = K_INVALID;
                            unique case (c)
                                8'h28: k = K_LPAR;
                                8'h29: k = K_RPAR;
                                8'h2c: k = K_COMMA;
                                8'h3b: k = K_SEMI;
                                8'h2e: k = K_DOT;
                                8'h2b: k = K_PLUS;
                                8'h2a: k = K_STAR;
                                8'h2f: k = K_SLASH;
                                8'h25: k = K_PCT;
                                8'h3d: k = K_EQ;
                                default: k = K_INVALID;
                            endcase
                            if (k != K_INVALID)
                            begin
                                r[n[1:0]] = '{k, p, 16'd1, lc_reg, colp, E_NONE, 1'b0};
                                n = n + 3'd1;
                            end
                            else
                            begin
                                r[n[1:0]] = '{K_INVALID, p, 16'd1, lc_reg, colp, E_UNEXPECTED, 1'b0};
                                r[n[1:0] + 2'd1] = '{K_EOF, p, 16'd0, lc_reg, colp, E_NONE, 1'b0};
                                n = n + 3'd2; halt_next = 1'b1;
                            end
                        end
                    end
                end
                if (n != 3'd0) r[n[1:0] - 2'd1].last = 1'b1;
            end
        end
        batch.recs = r;
        batch.count = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE; held_reg <= '0; tb_reg <= '0; xb_reg <= '0;
            sl_reg <= 16'd1; sc_reg <= 16'd1; lc_reg <= 16'd1; lb_reg <= '0;
            bp_reg <= '0; esc_reg <= 1'b0; halt_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next; held_reg <= held_next; tb_reg <= tb_next; xb_reg <= xb_next;
            sl_reg <= sl_next; sc_reg <= sc_next; lc_reg <= lc_next; lb_reg <= lb_next;
            bp_reg <= bp_next; esc_reg <= esc_next; halt_reg <= halt_next;
        end
    end
endmodule
`default_nettype wire

>>> design/sts_back.sv
`default_nettype none
module sts_back
(
    input  wire                 clk,
    input  wire                 rst_n,
    input  sts_pkg::batch_t     batch,
    output logic                full,
    output logic                empty,
    output logic                out_valid,
    input  wire                 out_stall,
    output sts_pkg::rec_t       out_rec
);
    import sts_pkg::*;

    batch_t         q_reg [QD];
    logic [QAW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic [1:0]     sub_reg, sub_next;
    logic           push, pop_batch, emit;
    batch_t         head;

    assign head = q_reg[rp_reg];
    assign push = batch.count != 3'd0;
    assign full = cnt_reg == (QAW+1)'(QD);
    assign empty = cnt_reg == '0;
    assign out_valid = !empty;
    assign out_rec = head.recs[sub_reg];
    assign emit = out_valid && !out_stall;
    assign pop_batch = emit && ({1'b0, sub_reg} == head.count - 3'd1);

    always_comb
    begin
        wp_next = push ? wp_reg + 1'b1 : wp_reg;
        rp_next = pop_batch ? rp_reg + 1'b1 : rp_reg;
        sub_next = pop_batch ? 2'd0 : (emit ? sub_reg + 2'd1 : sub_reg);
        cnt_next = cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop_batch);
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= batch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0; sub_reg <= '0;
        end
        else
        begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next; sub_reg <= sub_next;
        end
    end
endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import sts_pkg::*;

    typedef enum int {
        S_IDLE, S_NPEND, S_IDENT, S_AT, S_VAR, S_INT, S_INTDOT, S_DEC,
        S_STR, S_USTR, S_BRACK, S_OPPEND, S_MINUSGT
    } scan_t;

    typedef struct packed {
        logic       kind_end;
        logic [7:0] byte_val;
    } src_item_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] off;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic [2:0]  err;
        logic        last;
    } token_rec_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        req_type;
    logic [7:0]  ch;
    logic        out_valid;
    logic        out_stall;
    logic [4:0]  token_kind;
    logic [15:0] text_offset;
    logic [15:0] text_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic [2:0]  error_code;
    logic        last_of_run;

    sql_token_scanner dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .req_type(req_type), .ch(ch),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_kind(token_kind), .text_offset(text_offset), .text_length(text_length),
        .token_line(token_line), .token_column(token_column), .error_code(error_code),
        .last_of_run(last_of_run)
    );

    src_item_t  pending_src[$];
    token_rec_t expected_tokens[$];
    token_rec_t run_buf[$];
    int         send_idle_pct;
    int         recv_idle_pct;
    int         failures;
    longint     cycle_count;
    logic       stim_done;
    logic       in_done;

    scan_t       p_mode;
    logic [7:0]  p_held;
    logic [15:0] p_tok_begin;
    logic [15:0] p_text_begin;
    logic [15:0] p_start_line;
    logic [15:0] p_start_col;
    logic [15:0] p_line;
    logic [15:0] p_line_begin;
    logic [15:0] p_pos;
    logic        p_escape;
    logic        p_halted;

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic logic [15:0] inc16(input logic [15:0] x);
        return (x == 16'hFFFF) ? x : x + 16'd1;
    endfunction

    function automatic logic [15:0] column_at(input logic [15:0] pos);
        logic [15:0] d;
        d = (pos >= p_line_begin) ? pos - p_line_begin : 16'd0;
        return inc16(d);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    task automatic emit_at(input logic [4:0] kind, input logic [15:0] off,
                           input logic [15:0] len, input logic [15:0] line,
                           input logic [15:0] col, input logic [2:0] err);
        token_rec_t r;
        r = '{kind, off, len, line, col, err, 1'b0};
        if (run_buf.size() < 4)
            run_buf.push_back(r);
    endtask

    task automatic emit(input logic [4:0] kind, input logic [15:0] off,
                        input logic [15:0] len);
        emit_at(kind, off, len, p_start_line, p_start_col, E_NONE);
    endtask

    task automatic scan_error(input logic [2:0] err, input logic [15:0] off,
                              input logic [15:0] len);
        emit_at(K_INVALID, off, len, p_start_line, p_start_col, err);
        emit_at(K_EOF, off, 16'd0, p_start_line, p_start_col, E_NONE);
        p_halted = 1'b1;
        p_mode = S_IDLE;
    endtask

    task automatic line_feed(input logic [15:0] p);
        p_line = inc16(p_line);
        p_line_begin = inc16(p);
    endtask

    task automatic clear_scanner();
        p_mode = S_IDLE;
        p_held = 8'd0;
        p_tok_begin = 16'd0;
        p_text_begin = 16'd0;
        p_start_line = 16'd1;
        p_start_col = 16'd1;
        p_line = 16'd1;
        p_line_begin = 16'd0;
        p_pos = 16'd0;
        p_escape = 1'b0;
        p_halted = 1'b0;
    endtask

    task automatic begin_token(input logic [7:0] c, input logic [15:0] p);
        if (c == " " || c == 8'h09 || c == 8'h0D)
            return;
        if (c == 8'h0A)
        begin
            line_feed(p);
            return;
        end
        p_start_line = p_line;
        p_start_col = column_at(p);
        p_tok_begin = p;
        if (c == "N" || c == "n")
        begin
            p_mode = S_NPEND;
            p_held = c;
        end
        else if (is_alpha(c))
            p_mode = S_IDENT;
        else if (is_num(c))
            p_mode = S_INT;
        else
            case (c)
                8'h27:
                begin
                    p_mode = S_STR;
                    p_text_begin = inc16(p);
                    p_escape = 1'b0;
                end
                "[":
                begin
                    p_mode = S_BRACK;
                    p_text_begin = inc16(p);
                end
                "@": p_mode = S_AT;
                "(": emit(K_LPAR, p, 16'd1);
                ")": emit(K_RPAR, p, 16'd1);
                ",": emit(K_COMMA, p, 16'd1);
                ";": emit(K_SEMI, p, 16'd1);
                ".": emit(K_DOT, p, 16'd1);
                "+": emit(K_PLUS, p, 16'd1);
                "*": emit(K_STAR, p, 16'd1);
                "/": emit(K_SLASH, p, 16'd1);
                "%": emit(K_PCT, p, 16'd1);
                "=": emit(K_EQ, p, 16'd1);
                "-", "<", ">", "!":
                begin
                    p_mode = S_OPPEND;
                    p_held = c;
                end
                default: scan_error(E_UNEXPECTED, p, 16'd1);
            endcase
    endtask

    task automatic scan_byte(input logic [7:0] c, input logic [15:0] p);
        logic again;
        again = 1'b1;
        while (again)
        begin
            again = 1'b0;
            case (p_mode)
                S_NPEND:
                    if (c == 8'h27)
                    begin
                        p_mode = S_USTR;
                        p_tok_begin = p;
                        p_text_begin = inc16(p);
                        p_escape = 1'b0;
                    end
                    else
                    begin
                        p_mode = S_IDENT;
                        again = 1'b1;
                    end
                S_IDENT:
                    if (!(is_alpha(c) || is_num(c)))
                    begin
                        emit(K_IDENT, p_tok_begin, p - p_tok_begin);
                        p_mode = S_IDLE;
                        again = 1'b1;
                    end
                S_AT:
                    if (is_alpha(c))
                        p_mode = S_VAR;
                    else
                        scan_error(E_BAD_VAR, p_tok_begin, 16'd1);
                S_VAR:
                    if (!(is_alpha(c) || is_num(c)))
                    begin
                        emit(K_VAR, p_tok_begin, p - p_tok_begin);
                        p_mode = S_IDLE;
                        again = 1'b1;
                    end
                S_INT:
                    if (c == ".")
                    begin
                        p_text_begin = p;
                        p_mode = S_INTDOT;
                    end
                    else if (!is_num(c))
                    begin
                        emit(K_INT, p_tok_begin, p - p_tok_begin);
                        p_mode = S_IDLE;
                        again = 1'b1;
                    end
                S_INTDOT:
                    if (is_num(c))
                        p_mode = S_DEC;
                    else
                    begin
                        emit(K_INT, p_tok_begin, p_text_begin - p_tok_begin);
                        emit_at(K_DOT, p_text_begin, 16'd1, p_line,
                                column_at(p_text_begin), E_NONE);
                        p_mode = S_IDLE;
                        again = 1'b1;
                    end
                S_DEC:
                    if (!is_num(c))
                    begin
                        emit(K_DEC, p_tok_begin, p - p_tok_begin);
                        p_mode = S_IDLE;
                        again = 1'b1;
                    end
                S_STR, S_USTR:
                    if (p_escape)
                    begin
                        p_escape = 1'b0;
                        if (c == 8'h0A)
                            line_feed(p);
                    end
                    else if (c == 8'h27)
                    begin
                        emit((p_mode == S_STR) ? K_STR : K_USTR, p_text_begin,
                             p - p_text_begin);
                        p_mode = S_IDLE;
                    end
                    else if (c == 8'h5C)
                        p_escape = 1'b1;
                    else if (c == 8'h0A)
                        line_feed(p);
                S_BRACK:
                    if (c == "]")
                    begin
                        if (p == p_text_begin)
                            scan_error(E_EMPTY_BRACK, p_text_begin, 16'd0);
                        else
                        begin
                            emit(K_IDENT, p_text_begin, p - p_text_begin);
                            p_mode = S_IDLE;
                        end
                    end
                    else if (c == 8'h0A)
                        line_feed(p);
                S_OPPEND:
                begin
                    p_mode = S_IDLE;
                    again = 1'b1;
                    if (p_held == "-")
                    begin
                        if (c == ">")
                        begin
                            p_mode = S_MINUSGT;
                            again = 1'b0;
                        end
                        else
                            emit(K_MINUS, p_tok_begin, 16'd1);
                    end
                    else if (p_held == "<")
                    begin
                        if (c == "=" || c == ">")
                        begin
                            emit((c == "=") ? K_LE : K_NE, p_tok_begin, 16'd2);
                            again = 1'b0;
                        end
                        else
                            emit(K_LT, p_tok_begin, 16'd1);
                    end
                    else if (p_held == ">")
                    begin
                        if (c == "=")
                        begin
                            emit(K_GE, p_tok_begin, 16'd2);
                            again = 1'b0;
                        end
                        else
                            emit(K_GT, p_tok_begin, 16'd1);
                    end
                    else
                    begin
                        again = 1'b0;
                        if (c == "=")
                            emit(K_NE, p_tok_begin, 16'd2);
                        else
                            scan_error(E_LONE_BANG, p_tok_begin, 16'd1);
                    end
                end
                S_MINUSGT:
                begin
                    p_mode = S_IDLE;
                    if (c == ">")
                        emit(K_ARROW2, p_tok_begin, 16'd3);
                    else
                    begin
                        emit(K_ARROW, p_tok_begin, 16'd2);
                        again = 1'b1;
                    end
                end
                default:
                begin
                    p_mode = S_IDLE;
                    begin_token(c, p);
                end
            endcase
        end
    endtask

    task automatic flush_source();
        logic [15:0] p;
        p = p_pos;
        case (p_mode)
            S_NPEND, S_IDENT: emit(K_IDENT, p_tok_begin, p - p_tok_begin);
            S_AT: scan_error(E_BAD_VAR, p_tok_begin, 16'd1);
            S_VAR: emit(K_VAR, p_tok_begin, p - p_tok_begin);
            S_INT: emit(K_INT, p_tok_begin, p - p_tok_begin);
            S_INTDOT:
            begin
                emit(K_INT, p_tok_begin, p_text_begin - p_tok_begin);
                emit_at(K_DOT, p_text_begin, 16'd1, p_line, column_at(p_text_begin), E_NONE);
            end
            S_DEC: emit(K_DEC, p_tok_begin, p - p_tok_begin);
            S_STR, S_USTR: scan_error(E_UNTERM_STR, p_tok_begin, p - p_tok_begin);
            S_BRACK: scan_error(E_UNTERM_BRACK, p_text_begin, p - p_text_begin);
            S_OPPEND:
                if (p_held == "-")
                    emit(K_MINUS, p_tok_begin, 16'd1);
                else if (p_held == "<")
                    emit(K_LT, p_tok_begin, 16'd1);
                else if (p_held == ">")
                    emit(K_GT, p_tok_begin, 16'd1);
                else
                    scan_error(E_LONE_BANG, p_tok_begin, 16'd1);
            S_MINUSGT: emit(K_ARROW, p_tok_begin, 16'd2);
            default: ;
        endcase
        if (!p_halted)
            emit_at(K_EOF, p, 16'd0, p_line, column_at(p), E_NONE);
    endtask

    task automatic predict_tokens(input src_item_t it);
        run_buf.delete();
        if (it.kind_end)
        begin
            if (!p_halted)
                flush_source();
            clear_scanner();
        end
        else if (!p_halted)
        begin
            scan_byte(it.byte_val, p_pos);
            p_pos = inc16(p_pos);
        end
        if (run_buf.size() > 0)
            run_buf[run_buf.size() - 1].last = 1'b1;
        foreach (run_buf[i])
            expected_tokens.push_back(run_buf[i]);
    endtask

    task automatic add_byte(input logic [7:0] c);
        pending_src.push_back('{1'b0, c});
    endtask

    task automatic add_end();
        pending_src.push_back('{1'b1, 8'h00});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_byte(s[i]);
    endtask

    function automatic string pick_fragment();
        int sel;
        string s;
        int n;
        int k;
        string alnum;
        string digits;
        string ops;
        sel = $urandom_range(0, 21);
        s = "";
        n = $urandom_range(1, 5);
        alnum = "aZ_x9q";
        digits = "0123456789";
        ops = "(),;.+*/%=-<>";
        case (sel)
            0, 1: for (int i = 0; i < n; i++)
                begin
                    k = $urandom_range(0, 5);
                    s = {s, alnum.substr(k, k)};
                end
            2: for (int i = 0; i < n; i++)
                begin
                    k = $urandom_range(0, 9);
                    s = {s, digits.substr(k, k)};
                end
            3: s = "12.75";
            4: s = "3.";
            5: s = "'ab\\'c'";
            6: s = "N'xy'";
            7: s = "n1";
            8: s = "@v_1";
            9: s = "[col x]";
            10: s = "->>";
            11: s = "->";
            12: s = "<=";
            13: s = "<>";
            14: s = ">=";
            15: s = "!=";
            16: s = "\n";
            17:
            begin
                k = $urandom_range(0, 12);
                s = ops.substr(k, k);
            end
            18: s = "'l1\nl2'";
            19: s = "'t\\\n'";
            default: s = " ";
        endcase
        return s;
    endfunction

    initial
    begin
        int n_src;
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = 1'b0;
        ch = 8'h00;
        out_stall = 1'b0;
        failures = 0;
        cycle_count = 0;
        stim_done = 1'b0;
        in_done = 1'b0;
        send_idle_pct = 18;
        recv_idle_pct = 45;
        clear_scanner();

        add_text("SELECT a_1,N'x' FROM [t] WHERE @v>=12.5 AND n<>3.;");
        add_end();
        add_text("x->>y->z<=1<2>3>-4!=5(*)/%+");
        add_end();
        add_text("'a\\'b\nc'\n9.x");
        add_end();
        add_text("[]");
        add_end();
        add_text("@1");
        add_end();
        add_text("a!b");
        add_end();
        add_byte(8'hFF);
        add_byte(8'h80);
        add_end();
        add_text("'open");
        add_end();
        add_text("[open");
        add_end();
        add_text("N'u");
        add_end();
        add_text("@");
        add_end();
        add_text("! - < > -> N n 7. 7.5");
        add_end();
        add_end();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int phase = 0; phase < 3; phase++)
        begin
            n_src = 0;
            while (n_src < 65)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    add_byte(8'($urandom));
                    n_src++;
                end
                else
                begin
                    string s;
                    s = pick_fragment();
                    add_text(s);
                    n_src += s.len();
                    if ($urandom_range(0, 1) == 0)
                    begin
                        add_byte(" ");
                        n_src++;
                    end
                end
                if ($urandom_range(0, 14) == 0)
                    add_end();
            end
            add_end();
            while (pending_src.size() > 0 || expected_tokens.size() > 0)
                @(posedge clk);
            if (phase == 0)
            begin
                send_idle_pct = 45;
                recv_idle_pct = 18;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        end
        stim_done = 1'b1;
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            if (!in_valid || in_done)
            begin
                if (pending_src.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    req_type <= pending_src[0].kind_end;
                    ch <= pending_src[0].kind_end ? 8'($urandom) : pending_src[0].byte_val;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        token_rec_t got;
        token_rec_t want;
        in_done = rst_n && in_valid && !in_stall;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_tokens(pending_src.pop_front());
            if (out_valid && !out_stall)
            begin
                got = '{token_kind, text_offset, text_length, token_line, token_column,
                        error_code, last_of_run};
                if (expected_tokens.size() == 0)
                begin
                    $display("%0t: unexpected token record %h", $time, got);
                    failures++;
                end
                else
                begin
                    want = expected_tokens.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: token mismatch expected %h actual %h", $time, want, got);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 200000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_tokens.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire

>>> sim.f
design/sts_pkg.sv
design/sts_front.sv
design/sts_back.sv
design/sql_token_scanner.sv
tb/tb.sv
